[hdl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants for the descriptor splitter.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 21;
  localparam int COUNT_W   = 16;
  localparam int SLOT_OUT_W = 9;
  localparam int PIECE_W   = 17;

  localparam logic [PIECE_W-1:0] BLOCK_SIZE = 17'h10000;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISALIGNED = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN   = 3'd3;
  localparam logic [2:0] ST_EXCEEDS    = 3'd4;
  localparam logic [2:0] ST_FAILED     = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SPLIT
  } state_t;

  typedef struct packed {
    logic [PIECE_W-1:0] piece;
    logic               final_piece;
    logic [ADDR_W-1:0]  addr_next;
    logic [LEN_W-1:0]   rem_next;
  } step_t;

endpackage

[hdl/dps_step.sv]
// ----------------------------------------------------------------------------
// dps_step
// Cuts one piece off a segment at the next 64 KiB address boundary.
// ----------------------------------------------------------------------------
module dps_step (
  input  logic [dps_pkg::ADDR_W-1:0] addr,
  input  logic [dps_pkg::LEN_W-1:0]  remaining,
  output dps_pkg::step_t             step
);

  logic [dps_pkg::PIECE_W-1:0] to_boundary;
  logic                        rem_fits;

  always_comb begin
    to_boundary = dps_pkg::BLOCK_SIZE - {1'b0, addr[15:0]};
    rem_fits    = remaining <= dps_pkg::LEN_W'(to_boundary);
    step.piece       = rem_fits ? remaining[dps_pkg::PIECE_W-1:0] : to_boundary;
    step.final_piece = rem_fits;
    step.addr_next   = addr + dps_pkg::ADDR_W'(step.piece);
    step.rem_next    = remaining - dps_pkg::LEN_W'(step.piece);
  end

endmodule

[hdl/dma_prd_splitter_64k.sv]
// ----------------------------------------------------------------------------
// dma_prd_splitter_64k
// Turns scatter-gather segments into bus-master descriptors split at 64 KiB.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  first_segment, total_bytes,
//                                          seg_addr, seg_len
// out      output     out_valid / out_stall prd_addr, prd_count, end_of_table,
//                                          slot, status, last
//
// A segment is accepted in S_IDLE, checked in S_CHECK and then cut at 64 KiB
// boundaries in S_SPLIT; an error ends the segment with a single error beat.
// The single piece-cutting unit yields one piece a cycle unless the output stalls.
// Reset clears the byte count, the slot index and the error latch.
// A stall on the output holds the sequencer until the result beat is taken.
// ----------------------------------------------------------------------------
module dma_prd_splitter_64k #(
  parameter int TABLE_DEPTH  = 512,
  parameter int MAX_TRANSFER = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_segment,
  input  logic [20:0] total_bytes,
  input  logic [31:0] seg_addr,
  input  logic [20:0] seg_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] prd_addr,
  output logic [15:0] prd_count,
  output logic        end_of_table,
  output logic [8:0]  slot,
  output logic [2:0]  status,
  output logic        last
);

  localparam int SLOT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [SLOT_W-1:0] DEPTH = SLOT_W'(TABLE_DEPTH);
  localparam logic [24:0] MAX_T = 25'(MAX_TRANSFER);

  dps_pkg::state_t state, state_next;

  logic                         cmd_first;
  logic [dps_pkg::LEN_W-1:0]    cmd_total;
  logic [dps_pkg::ADDR_W-1:0]   cur_addr, cur_addr_next;
  logic [dps_pkg::LEN_W-1:0]    cur_len, cur_len_next;
  logic [dps_pkg::LEN_W-1:0]    bytes_left, bytes_left_next;
  logic [SLOT_W-1:0]            next_slot, next_slot_next;
  logic                         failed, failed_next;

  logic                         accept;
  logic                         out_free;
  logic                         load_out;
  logic [dps_pkg::LEN_W-1:0]    eff_left;
  logic [SLOT_W+8:0]            slot_ext;
  dps_pkg::step_t               step;

  logic [31:0] o_addr;
  logic [15:0] o_count;
  logic        o_eot;
  logic [8:0]  o_slot;
  logic [2:0]  o_status;
  logic        o_last;

  dps_step u_step (
    .addr      (cur_addr),
    .remaining (cur_len),
    .step      (step)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign slot_ext = {9'b0, next_slot};

  always_comb begin
    if ({4'b0, cmd_total} > MAX_T) begin
      eff_left = MAX_T[dps_pkg::LEN_W-1:0];
    end else begin
      eff_left = cmd_total;
    end
  end

  always_comb begin
    state_next      = state;
    cur_addr_next   = cur_addr;
    cur_len_next    = cur_len;
    bytes_left_next = bytes_left;
    next_slot_next  = next_slot;
    failed_next     = failed;
    in_stall        = (state != dps_pkg::S_IDLE);
    load_out        = 1'b0;
    o_addr          = '0;
    o_count         = '0;
    o_eot           = 1'b0;
    o_slot          = '0;
    o_status        = dps_pkg::ST_OK;
    o_last          = 1'b0;
    unique case (state)
      dps_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = dps_pkg::S_CHECK;
        end
      end
      dps_pkg::S_CHECK: begin
        if (out_free) begin
          load_out   = 1'b1;
          o_last     = 1'b1;
          state_next = dps_pkg::S_IDLE;
          if (!cmd_first && failed) begin
            o_status = dps_pkg::ST_FAILED;
          end else begin
            if (cmd_first) begin
              bytes_left_next = eff_left;
              next_slot_next  = '0;
              failed_next     = 1'b0;
            end
            if (cur_len == '0) begin
              o_status    = dps_pkg::ST_ZERO_LEN;
              failed_next = 1'b1;
            end else if (cur_addr[0]) begin
              o_status    = dps_pkg::ST_MISALIGNED;
              failed_next = 1'b1;
            end else if (cur_len > bytes_left_next) begin
              o_status    = dps_pkg::ST_EXCEEDS;
              failed_next = 1'b1;
            end else begin
              load_out        = 1'b0;
              o_last          = 1'b0;
              bytes_left_next = bytes_left_next - cur_len;
              state_next      = dps_pkg::S_SPLIT;
            end
          end
        end
      end
      dps_pkg::S_SPLIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (next_slot >= DEPTH) begin
            o_status    = dps_pkg::ST_TABLE_FULL;
            o_last      = 1'b1;
            failed_next = 1'b1;
            state_next  = dps_pkg::S_IDLE;
          end else begin
            o_addr         = cur_addr;
            o_count        = step.piece[15:0];
            o_eot          = step.final_piece && (bytes_left == '0);
            o_slot         = slot_ext[8:0];
            o_last         = step.final_piece;
            next_slot_next = next_slot + SLOT_W'(1);
            cur_addr_next  = step.addr_next;
            cur_len_next   = step.rem_next;
            if (step.final_piece) begin
              state_next = dps_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = dps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dps_pkg::S_IDLE;
      bytes_left <= '0;
      next_slot  <= '0;
      failed     <= 1'b0;
    end else begin
      state      <= state_next;
      bytes_left <= bytes_left_next;
      next_slot  <= next_slot_next;
      failed     <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_first <= first_segment;
      cmd_total <= total_bytes;
      cur_addr  <= seg_addr;
      cur_len   <= seg_len;
    end else begin
      cur_addr <= cur_addr_next;
      cur_len  <= cur_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      prd_addr     <= o_addr;
      prd_count    <= o_count;
      end_of_table <= o_eot;
      slot         <= o_slot;
      status       <= o_status;
      last         <= o_last;
    end
  end

`ifndef SYNTHESIS
  a_eot_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_table |-> last && (status == dps_pkg::ST_OK))
    else $error("End of table on a beat that does not close the segment.");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != dps_pkg::ST_OK) |-> last)
    else $error("Error beat without the last flag.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken while a segment is still in work.");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_slot <= DEPTH)
    else $error("Slot index ran past the table depth.");
`endif

endmodule

[tb/dma_prd_splitter_64k_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_prd_splitter_64k_test
// Self-checking bench for the 64 KiB descriptor splitter. Segments come from
// a queue through a randomly idling driver. A behavioral model predicts the
// descriptor and error beats, and a monitor compares each received beat
// with them.
// ----------------------------------------------------------------------------
module dma_prd_splitter_64k_test;

  localparam int MAX_XFER    = 1048576;
  localparam int TABLE_SLOTS = 512;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic        first;
    logic [20:0] total;
    logic [31:0] addr;
    logic [20:0] len;
  } sg_seg_t;

  typedef struct {
    logic [31:0] addr;
    logic [15:0] count;
    logic        eot;
    logic [8:0]  slot;
    logic [2:0]  status;
    logic        last;
  } prd_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        first_segment = 1'b0;
  logic [20:0] total_bytes = '0;
  logic [31:0] seg_addr = '0;
  logic [20:0] seg_len = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] prd_addr;
  logic [15:0] prd_count;
  logic        end_of_table;
  logic [8:0]  slot;
  logic [2:0]  status;
  logic        last;

  sg_seg_t sg_backlog[$];
  prd_t    pending_prds[$];
  sg_seg_t on_bus;
  prd_t    want;

  logic [20:0] left_bytes = '0;
  logic [9:0]  slot_next = '0;
  logic        cmd_failed = 1'b0;

  int   items_pushed = 0;
  int   items_taken = 0;
  int   fails = 0;
  int   tx_idle_pct = 22;
  int   rx_idle_pct = 62;
  int   phase = 1;
  logic rx_hold = 1'b0;

  dma_prd_splitter_64k uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_segment(first_segment),
    .total_bytes  (total_bytes),
    .seg_addr     (seg_addr),
    .seg_len      (seg_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .prd_addr     (prd_addr),
    .prd_count    (prd_count),
    .end_of_table (end_of_table),
    .slot         (slot),
    .status       (status),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void add_error(input logic [2:0] code);
    prd_t r;
    r.addr = '0;
    r.count = '0;
    r.eot = 1'b0;
    r.slot = '0;
    r.status = code;
    r.last = 1'b1;
    cmd_failed = 1'b1;
    pending_prds.push_back(r);
  endfunction

  function automatic void predict_prds(input sg_seg_t s);
    logic [31:0] a;
    logic [20:0] rem;
    logic [20:0] piece;
    logic [16:0] to_bnd;
    prd_t        r;
    if (s.first) begin
      left_bytes = (s.total > MAX_XFER) ? 21'(MAX_XFER) : s.total;
      slot_next = '0;
      cmd_failed = 1'b0;
    end else if (cmd_failed) begin
      add_error(dps_pkg::ST_FAILED);
      return;
    end
    if (s.len == 0) begin
      add_error(dps_pkg::ST_ZERO_LEN);
      return;
    end
    if (s.addr[0]) begin
      add_error(dps_pkg::ST_MISALIGNED);
      return;
    end
    if (s.len > left_bytes) begin
      add_error(dps_pkg::ST_EXCEEDS);
      return;
    end
    left_bytes = left_bytes - s.len;
    a = s.addr;
    rem = s.len;
    while (rem != 0) begin
      to_bnd = dps_pkg::BLOCK_SIZE - {1'b0, a[15:0]};
      piece = (rem < to_bnd) ? rem : 21'(to_bnd);
      if (slot_next >= TABLE_SLOTS) begin
        add_error(dps_pkg::ST_TABLE_FULL);
        return;
      end
      r.addr = a;
      r.count = piece[15:0];
      r.eot = (piece == rem) && (left_bytes == 0);
      r.slot = slot_next[8:0];
      r.status = dps_pkg::ST_OK;
      r.last = (piece == rem);
      pending_prds.push_back(r);
      slot_next = slot_next + 1'b1;
      a = a + piece;
      rem = rem - piece;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_prds(on_bus);
        items_taken++;
      end
      if (sg_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        on_bus = sg_backlog.pop_front();
        in_valid <= 1'b1;
        first_segment <= on_bus.first;
        total_bytes <= on_bus.total;
        seg_addr <= on_bus.addr;
        seg_len <= on_bus.len;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_prds.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          want = pending_prds.pop_front();
          check_field("prd_addr", want.addr, prd_addr);
          check_field("prd_count", 32'(want.count), 32'(prd_count));
          check_field("end_of_table", 32'(want.eot), 32'(end_of_table));
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("status", 32'(want.status), 32'(status));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // A long receiver hold while the sender keeps offering fills the block.
  initial begin
    wait (phase == 3);
    repeat (5) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_seg(input logic first, input logic [20:0] total,
                          input logic [31:0] addr, input logic [20:0] len);
    sg_seg_t s;
    s.first = first;
    s.total = total;
    s.addr = addr;
    s.len = len;
    sg_backlog.push_back(s);
    items_pushed++;
  endtask

  task automatic add_command();
    int          nseg;
    logic [20:0] total;
    logic [20:0] left;
    logic [20:0] len;
    logic [31:0] a;
    int          i;
    nseg = $urandom_range(1, 4);
    case ($urandom_range(9))
      0: total = 21'($urandom_range(1, MAX_XFER));
      1: total = 21'($urandom_range(MAX_XFER + 1, 21'h1fffff));
      default: total = 21'($urandom_range(2, 200000));
    endcase
    left = (total > MAX_XFER) ? 21'(MAX_XFER) : total;
    i = 0;
    while (i < nseg && left != 0) begin
      a = $urandom;
      case ($urandom_range(2))
        0: a[15:0] = 16'(16'hfffe - 2 * $urandom_range(0, 63));
        1: a[15:0] = 16'h0000;
        default: a[0] = 1'b0;
      endcase
      len = (i == nseg - 1) ? left : 21'($urandom_range(1, left));
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: a[0] = 1'b1;
          1: len = '0;
          2: len = 21'(left + $urandom_range(1, 4096));
          default: len = 21'($urandom_range(0, 21'h1fffff));
        endcase
      end else begin
        left = left - len;
      end
      push_seg(i == 0, (i == 0) ? total : 21'($urandom), a, len);
      i++;
    end
    if ($urandom_range(7) == 0)
      push_seg(1'b0, 21'($urandom), $urandom & 32'hfffffffe,
               21'($urandom_range(1, 4096)));
  endtask

  task automatic drain();
    while (items_taken != items_pushed) @(negedge clk);
    while (pending_prds.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] a;
    // Directed segments covering the corner cases.
    push_seg(1'b0, 21'h1fffff, 32'h0000_1000, 21'd2);
    push_seg(1'b1, 21'd0, 32'h0000_0100, 21'd0);
    push_seg(1'b1, 21'd0, 32'h0000_0100, 21'd2);
    push_seg(1'b0, 21'd0, 32'h0000_0200, 21'd2);
    push_seg(1'b1, 21'd100, 32'h0000_0301, 21'd2);
    push_seg(1'b1, 21'd7, 32'h0000_0000, 21'd7);
    push_seg(1'b1, 21'h1fffff, 32'hffff_0002, 21'h100000);
    push_seg(1'b1, 21'h100000, 32'h0000_0000, 21'h100000);
    push_seg(1'b1, 21'h100000, 32'hffff_fffe, 21'h1fffff);
    push_seg(1'b1, 21'h30000, 32'h0001_0000, 21'h10000);
    push_seg(1'b0, 21'h0aaaaa, 32'habcd_fff0, 21'h10000);
    push_seg(1'b0, 21'h155555, 32'h2000_0000, 21'h10000);
    push_seg(1'b0, 21'd0, 32'h0000_4000, 21'd2);
    push_seg(1'b0, 21'd0, 32'h0000_4000, 21'd2);
    push_seg(1'b1, 21'h40, 32'hffff_fffe, 21'h40);
    push_seg(1'b1, 21'h10, 32'hffff_ffff, 21'h10);
    push_seg(1'b1, 21'd100, 32'h0000_0010, 21'd50);
    push_seg(1'b0, 21'd0, 32'h0000_0040, 21'd0);
    push_seg(1'b0, 21'd0, 32'h0000_0040, 21'd50);
    // Fill the descriptor table with boundary-straddling segments of two
    // pieces each, then overflow it part way through a segment.
    push_seg(1'b1, 21'($urandom_range(70000, 21'h1fffff)),
             ($urandom & 32'hffff_0000) | 32'h0000_fffe, 21'd4);
    for (int i = 1; i < TABLE_SLOTS / 2 - 1; i++) begin
      a = ($urandom & 32'hffff_0000) | 32'h0000_fffe;
      push_seg(1'b0, 21'($urandom), a, 21'd4);
    end
    push_seg(1'b0, 21'($urandom), ($urandom & 32'hffff_0000) | 32'h0000_fffe,
             21'd65540);
    push_seg(1'b0, 21'($urandom), $urandom & 32'hfffffffe, 21'd2);
    while (items_pushed < 300) add_command();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    drain();
    @(negedge clk);
    tx_idle_pct = 62;
    rx_idle_pct = 22;
    while (items_pushed < 365) add_command();

    drain();
    @(negedge clk);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase = 3;
    while (items_pushed < 430) add_command();

    drain();
    repeat (40) @(negedge clk);
    if (fails == 0 && pending_prds.size() == 0)
      $display("dma_prd_splitter_64k_test passed");
    else
      $display("dma_prd_splitter_64k_test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dma_prd_splitter_64k_test failed");
    $finish;
  end

endmodule

[sim.f]
hdl/dps_pkg.sv
hdl/dps_step.sv
hdl/dma_prd_splitter_64k.sv
tb/dma_prd_splitter_64k_test.sv
